### design/oarb_pkg.sv
// Package for the overlap-add reblock buffer: defaults, register indexes,
// command codes and the operation struct passed from the pointer unit.
// No dependencies.
`default_nettype none
package oarb_pkg;

   localparam int STORE_DEPTH_DEF = 1024;
   localparam int SAMPLE_BITS_DEF = 24;

   localparam int CFG_BITS       = 11;  // buffer_size, hop_size
   localparam int START_BITS     = 10;  // read_start, write_start
   localparam int CSR_INDEX_BITS = 2;

   localparam logic [CFG_BITS-1:0]   BUFFER_SIZE_RST = 11'd64;
   localparam logic [CFG_BITS-1:0]   HOP_SIZE_RST    = 11'd64;
   localparam logic [START_BITS-1:0] READ_START_RST  = 10'd0;
   localparam logic [START_BITS-1:0] WRITE_START_RST = 10'd0;

   // result queue
   localparam int FIFO_DEPTH    = 3;
   localparam int FIFO_PTR_BITS = 2;
   localparam int FIFO_CNT_BITS = 2;

   typedef enum logic [1:0] {
      CMD_ACC     = 2'd0,
      CMD_READ    = 2'd1,
      CMD_RESTART = 2'd2,
      CMD_NOP     = 2'd3
   } cmd_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_BUFFER_SIZE = 2'd0,
      REG_HOP_SIZE    = 2'd1,
      REG_READ_START  = 2'd2,
      REG_WRITE_START = 2'd3
   } reg_index_type;

   // what the store access of one beat does
   typedef struct packed {
      logic acc;  // add sample, write back saturated sum
      logic rd;   // return entry, write back zero
   } op_type;

endpackage
`default_nettype wire

### design/oarb_if.sv
// Channel interfaces of the overlap-add reblock buffer: request, response
// and register write. Depends on oarb_pkg.
`default_nettype none
interface oarb_req_if #(parameter int SAMPLE_BITS = oarb_pkg::SAMPLE_BITS_DEF);
   logic                          valid;
   logic                          ready;
   logic [1:0]                    cmd;
   logic signed [SAMPLE_BITS-1:0] sample_in;
   logic                          last;
   modport source (output valid, cmd, sample_in, last, input ready);
   modport sink   (input valid, cmd, sample_in, last, output ready);
endinterface

interface oarb_rsp_if #(parameter int SAMPLE_BITS = oarb_pkg::SAMPLE_BITS_DEF);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample_out;
   modport source (output valid, sample_out, input ready);
   modport sink   (input valid, sample_out, output ready);
endinterface

interface oarb_csr_if;
   logic                                  valid;
   logic                                  ready;
   logic [oarb_pkg::CSR_INDEX_BITS-1:0]   index;
   logic [oarb_pkg::CFG_BITS-1:0]         wdata;
   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface
`default_nettype wire

### design/oarb_ram.sv
// Sample store: one write port, one read port, registered read data.
// No dependencies.
`default_nettype none
module oarb_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 24,
   parameter int ADDR_BITS = 10
) (
   input  wire logic                 clock,
   input  wire logic                 we,
   input  wire logic [ADDR_BITS-1:0] waddr,
   input  wire logic [WIDTH-1:0]     wdata,
   input  wire logic [ADDR_BITS-1:0] raddr,
   output logic      [WIDTH-1:0]     rdata
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         store_ff[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      rdata_ff <= store_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

### design/oarb_ptr.sv
// Pointer unit: configuration registers, write/read pointers, block start.
// Picks the store address and operation of each accepted beat. Uses oarb_pkg, oarb_if.
`default_nettype none
module oarb_ptr #(
   parameter int STORE_DEPTH = oarb_pkg::STORE_DEPTH_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   oarb_csr_if.sink                   csr_ch,
   input  wire logic                  accept,
   input  wire oarb_pkg::cmd_type     cmd,
   input  wire logic                  last,
   output logic [$clog2(STORE_DEPTH)-1:0] addr,
   output oarb_pkg::op_type           op
);

   localparam int PW = $clog2(STORE_DEPTH);
   localparam int CW = ((PW > oarb_pkg::CFG_BITS) ? PW : oarb_pkg::CFG_BITS) + 1;
   localparam logic [CW-1:0] DEPTH_C = CW'(STORE_DEPTH);
   localparam logic [CW-1:0] ONE_C   = CW'(1);

   logic [oarb_pkg::CFG_BITS-1:0]   buf_size_ff, hop_size_ff;
   logic [oarb_pkg::START_BITS-1:0] rd_start_ff, wr_start_ff;
   logic [PW-1:0] wp_ff, wp_in, rp_ff, rp_in, bstart_ff, bstart_in;
   logic          in_block_ff, in_block_in;

   logic [CW-1:0] size_raw, eff_size, wp_inc, rp_inc, nx, rs_ext, ws_ext;
   logic [PW-1:0] wp_adv, rp_adv, bs_cur, rs_ld, ws_ld;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_size_ff <= oarb_pkg::BUFFER_SIZE_RST;
         hop_size_ff <= oarb_pkg::HOP_SIZE_RST;
         rd_start_ff <= oarb_pkg::READ_START_RST;
         wr_start_ff <= oarb_pkg::WRITE_START_RST;
      end else if (csr_ch.valid) begin
         case (oarb_pkg::reg_index_type'(csr_ch.index))
            oarb_pkg::REG_BUFFER_SIZE: buf_size_ff <= csr_ch.wdata;
            oarb_pkg::REG_HOP_SIZE:    hop_size_ff <= csr_ch.wdata;
            oarb_pkg::REG_READ_START:
               rd_start_ff <= csr_ch.wdata[oarb_pkg::START_BITS-1:0];
            oarb_pkg::REG_WRITE_START:
               wr_start_ff <= csr_ch.wdata[oarb_pkg::START_BITS-1:0];
            default: ;
         endcase
      end
   end

   // size in use: zero acts as one, clipped to the store depth
   always_comb begin
      size_raw = CW'(buf_size_ff);
      if (size_raw == '0) begin
         eff_size = ONE_C;
      end else if (size_raw > DEPTH_C) begin
         eff_size = DEPTH_C;
      end else begin
         eff_size = size_raw;
      end
      wp_inc = CW'(wp_ff) + ONE_C;
      rp_inc = CW'(rp_ff) + ONE_C;
      wp_adv = (wp_inc >= eff_size) ? '0 : wp_inc[PW-1:0];
      rp_adv = (rp_inc >= eff_size) ? '0 : rp_inc[PW-1:0];
      bs_cur = in_block_ff ? bstart_ff : wp_ff;
      nx     = CW'(bs_cur) + CW'(hop_size_ff);
      rs_ext = CW'(rd_start_ff);
      ws_ext = CW'(wr_start_ff);
      rs_ld  = (rs_ext >= eff_size) ? '0 : rs_ext[PW-1:0];
      ws_ld  = (ws_ext >= eff_size) ? '0 : ws_ext[PW-1:0];
   end

   always_comb begin
      wp_in       = wp_ff;
      rp_in       = rp_ff;
      bstart_in   = bstart_ff;
      in_block_in = in_block_ff;
      addr        = wp_ff;
      op          = '0;
      case (cmd)
         oarb_pkg::CMD_ACC: begin
            op.acc    = 1'b1;
            bstart_in = bs_cur;
            if (last) begin
               wp_in       = (nx >= eff_size) ? '0 : nx[PW-1:0];
               in_block_in = 1'b0;
            end else begin
               wp_in       = wp_adv;
               in_block_in = 1'b1;
            end
         end
         oarb_pkg::CMD_READ: begin
            op.rd = 1'b1;
            addr  = rp_ff;
            rp_in = rp_adv;
         end
         oarb_pkg::CMD_RESTART: begin
            rp_in       = rs_ld;
            wp_in       = ws_ld;
            bstart_in   = ws_ld;
            in_block_in = 1'b0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff       <= '0;
         rp_ff       <= '0;
         bstart_ff   <= '0;
         in_block_ff <= 1'b0;
      end else if (accept) begin
         wp_ff       <= wp_in;
         rp_ff       <= rp_in;
         bstart_ff   <= bstart_in;
         in_block_ff <= in_block_in;
      end
   end

endmodule
`default_nettype wire

### design/oarb_fifo.sv
// Three-entry result queue driving the response channel.
// Uses oarb_pkg, oarb_if.
`default_nettype none
module oarb_fifo #(
   parameter int SAMPLE_BITS = oarb_pkg::SAMPLE_BITS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire logic [SAMPLE_BITS-1:0] push_data,
   output logic [oarb_pkg::FIFO_CNT_BITS-1:0] count,
   oarb_rsp_if.source                  rsp_ch
);

   localparam logic [oarb_pkg::FIFO_PTR_BITS-1:0] LAST_IDX =
      oarb_pkg::FIFO_PTR_BITS'(oarb_pkg::FIFO_DEPTH - 1);

   logic [SAMPLE_BITS-1:0] entry_ff [oarb_pkg::FIFO_DEPTH];
   logic [oarb_pkg::FIFO_PTR_BITS-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [oarb_pkg::FIFO_CNT_BITS-1:0] count_ff;
   logic pop;

   assign rsp_ch.valid      = (count_ff != '0);
   assign rsp_ch.sample_out = entry_ff[rd_ptr_ff];
   assign pop               = rsp_ch.valid && rsp_ch.ready;
   assign count             = count_ff;

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_IDX) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_IDX) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule
`default_nettype wire

### design/overlap_add_reblock_buffer.sv
// Top level of the overlap-add reblock buffer: store access stage, clearing
// pass, forwarding. Uses oarb_pkg, oarb_if, oarb_ram, oarb_ptr, oarb_fifo.
//
//   channel  | dir | beat fields                   | handshake
//   ---------+-----+-------------------------------+------------
//   req_ch   | in  | cmd, sample_in, last          | valid/ready
//   rsp_ch   | out | sample_out                    | valid/ready
//   csr_ch   | in  | index, wdata                  | valid/ready
//
// One request beat per cycle while req_ch.ready is high; each gives one response
// beat (store read, then read-modify-write into the result queue).
// Back-to-back beats on one entry are covered by forwarding the last write.
// After reset a clearing pass zeroes the store, one entry per cycle, with
// req_ch.ready low until it is done; csr writes are taken throughout.
// Outside the clearing pass req_ch.ready drops only when the three-entry
// queue and the store-stage beat leave no room; the queue absorbs rsp stalls.
`default_nettype none
module overlap_add_reblock_buffer #(
   parameter int STORE_DEPTH = oarb_pkg::STORE_DEPTH_DEF,
   parameter int SAMPLE_BITS = oarb_pkg::SAMPLE_BITS_DEF
) (
   input wire logic   clock,
   input wire logic   reset,
   oarb_req_if.sink   req_ch,
   oarb_rsp_if.source rsp_ch,
   oarb_csr_if.sink   csr_ch
);

   localparam int PW = $clog2(STORE_DEPTH);
   localparam logic [PW-1:0] LAST_ADDR = PW'(STORE_DEPTH - 1);
   localparam logic signed [SAMPLE_BITS:0] MAX_C = (SAMPLE_BITS+1)'((1 << (SAMPLE_BITS-1)) - 1);
   localparam logic signed [SAMPLE_BITS:0] MIN_C = ~MAX_C;

   logic accept;
   logic [PW-1:0] acc_addr;
   oarb_pkg::op_type acc_op;

   // clearing pass after reset
   logic          clear_ff;
   logic [PW-1:0] clear_addr_ff;

   // store stage
   logic                   s1_valid_ff;
   oarb_pkg::op_type       s1_op_ff;
   logic [PW-1:0]          s1_addr_ff;
   logic [SAMPLE_BITS-1:0] s1_sample_ff;

   // last write, for a read issued at the same edge
   logic                   lw_valid_ff;
   logic [PW-1:0]          lw_addr_ff;
   logic [SAMPLE_BITS-1:0] lw_data_ff;

   logic [SAMPLE_BITS-1:0] ram_rdata, cur, wr_data, result;
   logic signed [SAMPLE_BITS:0] sum;
   logic                   s1_we, ram_we;
   logic [PW-1:0]          ram_waddr;
   logic [SAMPLE_BITS-1:0] ram_wdata;
   logic [oarb_pkg::FIFO_CNT_BITS-1:0] q_count;
   logic [oarb_pkg::FIFO_CNT_BITS:0]   in_flight;

   // room check does not look at rsp_ch.ready
   assign in_flight    = (oarb_pkg::FIFO_CNT_BITS+1)'(q_count)
                       + (oarb_pkg::FIFO_CNT_BITS+1)'(s1_valid_ff);
   assign req_ch.ready = !clear_ff &&
                         (in_flight < (oarb_pkg::FIFO_CNT_BITS+1)'(oarb_pkg::FIFO_DEPTH));
   assign accept       = req_ch.valid && req_ch.ready;

   oarb_ptr #(
      .STORE_DEPTH(STORE_DEPTH)
   ) u_ptr (
      .clock (clock),
      .reset (reset),
      .csr_ch(csr_ch),
      .accept(accept),
      .cmd   (oarb_pkg::cmd_type'(req_ch.cmd)),
      .last  (req_ch.last),
      .addr  (acc_addr),
      .op    (acc_op)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff      <= 1'b1;
         clear_addr_ff <= '0;
      end else if (clear_ff) begin
         clear_addr_ff <= clear_addr_ff + 1'b1;
         if (clear_addr_ff == LAST_ADDR) begin
            clear_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      s1_op_ff     <= acc_op;
      s1_addr_ff   <= acc_addr;
      s1_sample_ff <= req_ch.sample_in;
   end

   // read-modify-write
   always_comb begin
      cur = (lw_valid_ff && (lw_addr_ff == s1_addr_ff)) ? lw_data_ff : ram_rdata;
      sum = $signed({cur[SAMPLE_BITS-1], cur})
          + $signed({s1_sample_ff[SAMPLE_BITS-1], s1_sample_ff});
      if (sum > MAX_C) begin
         wr_data = MAX_C[SAMPLE_BITS-1:0];
      end else if (sum < MIN_C) begin
         wr_data = MIN_C[SAMPLE_BITS-1:0];
      end else begin
         wr_data = sum[SAMPLE_BITS-1:0];
      end
      if (!s1_op_ff.acc) begin
         wr_data = '0;   // read clears the entry
      end
      result = s1_op_ff.rd ? cur : '0;
      s1_we  = s1_valid_ff && (s1_op_ff.acc || s1_op_ff.rd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lw_valid_ff <= 1'b0;
      end else begin
         lw_valid_ff <= s1_we;
      end
   end

   always_ff @(posedge clock) begin
      lw_addr_ff <= s1_addr_ff;
      lw_data_ff <= wr_data;
   end

   assign ram_we    = clear_ff || s1_we;
   assign ram_waddr = clear_ff ? clear_addr_ff : s1_addr_ff;
   assign ram_wdata = clear_ff ? '0 : wr_data;

   oarb_ram #(
      .DEPTH    (STORE_DEPTH),
      .WIDTH    (SAMPLE_BITS),
      .ADDR_BITS(PW)
   ) u_ram (
      .clock(clock),
      .we   (ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .raddr(acc_addr),
      .rdata(ram_rdata)
   );

   oarb_fifo #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (s1_valid_ff),
      .push_data(result),
      .count    (q_count),
      .rsp_ch   (rsp_ch)
   );

endmodule
`default_nettype wire

### design/oarb_checker.sv
// Port-level checks for the overlap-add reblock buffer, bound to the top level.
// Depends on oarb_pkg and overlap_add_reblock_buffer.
`default_nettype none
module oarb_checker #(
   parameter int SAMPLE_BITS = oarb_pkg::SAMPLE_BITS_DEF
) (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_valid,
   input wire logic                   req_ready,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_ready,
   input wire logic [SAMPLE_BITS-1:0] sample_out
);

   logic [2:0] outst_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         outst_ff <= '0;
      end else begin
         outst_ff <= outst_ff + 3'(req_valid && req_ready) - 3'(rsp_valid && rsp_ready);
      end
   end

   // clearing pass holds off requests
   a_clear_after_reset: assert property (@(posedge clock) reset |=> !req_ready)
      else $error("request taken during clearing pass");

   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (outst_ff != 3'd0))
      else $error("response beat without an outstanding request");

   a_bounded: assert property (@(posedge clock) disable iff (reset)
      outst_ff <= 3'd4)
      else $error("more beats in flight than the buffer holds");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(sample_out))
      else $error("stalled response beat changed");

endmodule

bind overlap_add_reblock_buffer oarb_checker #(
   .SAMPLE_BITS(SAMPLE_BITS)
) u_oarb_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .sample_out(rsp_ch.sample_out)
);
`default_nettype wire

### bench/tb_top.sv
// Self-checking bench for overlap_add_reblock_buffer: directed and random beats,
// each result checked against an in-bench mirror of the store and pointers.
// Depends on oarb_pkg, oarb_if and the design sources.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import oarb_pkg::*;

   localparam int DEPTH    = STORE_DEPTH_DEF;
   localparam int SBITS    = SAMPLE_BITS_DEF;
   localparam int SAT_MAX  = (1 << (SBITS - 1)) - 1;
   localparam int SAT_MIN  = -(1 << (SBITS - 1));
   localparam int LIMIT_NS = 3_000_000;  // timeout, far beyond the slowest run

   localparam logic signed [SBITS-1:0] FULL_POS = SBITS'(SAT_MAX);
   localparam logic signed [SBITS-1:0] FULL_NEG = SBITS'(SAT_MIN);

   logic clock;
   logic reset;

   oarb_req_if req_ch ();
   oarb_rsp_if rsp_ch ();
   oarb_csr_if csr_ch ();

   overlap_add_reblock_buffer uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // mirror of the store, pointers and registers
   logic signed [SBITS-1:0] mirror_store [DEPTH];
   int                      wr_ptr;
   int                      rd_ptr;
   int                      blk_start;
   logic                    blk_open;
   logic [CFG_BITS-1:0]     cfg_size;
   logic [CFG_BITS-1:0]     cfg_hop;
   logic [START_BITS-1:0]   cfg_rd_start;
   logic [START_BITS-1:0]   cfg_wr_start;

   // samples still owed by the block, oldest first
   logic signed [SBITS-1:0] pending_samples [$];

   int   err_count     = 0;
   int   beats_sent    = 0;
   int   rx_wait       = 0;
   int   rsp_hold_left = 0;  // long receiver hold-off, counted down by the receiver
   logic tx_steady     = 1'b0;
   logic rx_steady     = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard stop in case the block hangs
   initial begin
      #(LIMIT_NS);
      $display("Test completed with failures");
      $finish;
   end

   function automatic void note_failure(input string msg);
      err_count++;
      if (err_count <= 10) $display("%0t %s", $time, msg);
   endfunction

   function automatic int step_ptr(input int p, input int size);
      return (p + 1 >= size) ? 0 : p + 1;
   endfunction

   // Applies one accepted beat to the mirror; returns the sample owed for it.
   function automatic logic signed [SBITS-1:0] ola_step(input cmd_type c,
                                                        input logic signed [SBITS-1:0] s,
                                                        input logic l);
      int                      size;
      int                      idx;
      int                      total;
      int                      nxt;
      logic signed [SBITS-1:0] read_val;
      size     = int'(cfg_size);
      read_val = '0;
      if (size == 0) size = 1;
      if (size > DEPTH) size = DEPTH;
      case (c)
         CMD_ACC: begin
            idx = wr_ptr % DEPTH;
            if (!blk_open) begin
               blk_start = wr_ptr;
               blk_open  = 1'b1;
            end
            total = int'(mirror_store[idx]) + int'(s);
            if (total > SAT_MAX) total = SAT_MAX;
            if (total < SAT_MIN) total = SAT_MIN;
            mirror_store[idx] = SBITS'(total);
            wr_ptr = step_ptr(wr_ptr, size);
            if (l) begin
               // block end: jump to start plus hop, or home if past the size
               nxt      = blk_start + int'(cfg_hop);
               wr_ptr   = (nxt >= size) ? 0 : nxt;
               blk_open = 1'b0;
            end
         end
         CMD_READ: begin
            idx               = rd_ptr % DEPTH;
            read_val          = mirror_store[idx];
            mirror_store[idx] = '0;
            rd_ptr            = step_ptr(rd_ptr, size);
         end
         CMD_RESTART: begin
            rd_ptr    = (int'(cfg_rd_start) >= size) ? 0 : int'(cfg_rd_start);
            wr_ptr    = (int'(cfg_wr_start) >= size) ? 0 : int'(cfg_wr_start);
            blk_start = wr_ptr;
            blk_open  = 1'b0;
         end
         default: ;  // unused command: nothing moves
      endcase
      return read_val;
   endfunction

   // mostly modest values so sums rarely clip, some full range, some rails
   function automatic logic signed [SBITS-1:0] draw_sample();
      case ($urandom_range(0, 9))
         0:       return FULL_POS;
         1:       return FULL_NEG;
         2, 3:    return SBITS'($urandom());
         default: return SBITS'(int'($urandom_range(0, 262143)) - 131072);
      endcase
   endfunction

   // Entered and left just after a falling edge.
   task automatic send_beat(input cmd_type c, input logic signed [SBITS-1:0] s,
                            input logic l);
      int gap;
      gap = tx_steady ? 0 : $urandom_range(0, 9);
      repeat (gap) @(negedge clock);
      req_ch.valid     = 1'b1;
      req_ch.cmd       = c;
      req_ch.sample_in = s;
      req_ch.last      = l;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      pending_samples.push_back(ola_step(c, s, l));
      beats_sent++;
      @(negedge clock);
      req_ch.valid = 1'b0;  // the next beat may raise it again at this edge
   endtask

   task automatic write_reg(input reg_index_type idx, input logic [CFG_BITS-1:0] val);
      csr_ch.valid = 1'b1;
      csr_ch.index = idx;
      csr_ch.wdata = val;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      case (idx)
         REG_BUFFER_SIZE: cfg_size     = val;
         REG_HOP_SIZE:    cfg_hop      = val;
         REG_READ_START:  cfg_rd_start = val[START_BITS-1:0];
         REG_WRITE_START: cfg_wr_start = val[START_BITS-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_ch.valid = 1'b0;
   endtask

   // every beat owes one result, so an empty queue means the block is idle
   task automatic wait_results_drained();
      while (pending_samples.size() != 0) @(negedge clock);
   endtask

   // receiver: per-beat random wait, plus the long hold-off when asked
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_left > 0) begin
            rsp_ch.ready = 1'b0;
            rsp_hold_left--;
         end else if (rx_wait > 0) begin
            rsp_ch.ready = 1'b0;
            rx_wait--;
         end else begin
            rsp_ch.ready = 1'b1;
         end
      end
   end

   always @(posedge clock) begin : check_results
      logic signed [SBITS-1:0] want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_samples.size() == 0) begin
            note_failure($sformatf("unexpected beat: sample_out %0d", rsp_ch.sample_out));
         end else begin
            want = pending_samples.pop_front();
            if (rsp_ch.sample_out !== want)
               note_failure($sformatf("sample_out mismatch: expected %0d got %0d",
                                      want, rsp_ch.sample_out));
         end
         rx_wait = rx_steady ? 0 : $urandom_range(0, 9);
      end
   end

   // Clipping at both rails, hop of zero, unused command, stray last flags.
   task automatic test_saturation_and_commands();
      write_reg(REG_BUFFER_SIZE, 11'd4);
      write_reg(REG_HOP_SIZE, 11'd0);
      // zero hop: each one-sample block lands back on entry 0
      send_beat(CMD_ACC, FULL_POS, 1'b1);
      send_beat(CMD_ACC, FULL_POS, 1'b1);      // clips high
      send_beat(CMD_ACC, FULL_NEG, 1'b1);      // down to -1 lsb
      send_beat(CMD_ACC, FULL_NEG, 1'b1);      // clips low
      send_beat(CMD_READ, '0, 1'b1);           // last is ignored here
      send_beat(CMD_NOP, 24'sh5A5A5A, 1'b1);
      send_beat(CMD_ACC, 24'sh000123, 1'b0);   // opens a block
      send_beat(CMD_RESTART, FULL_NEG, 1'b1);  // closes it, both pointers home
      send_beat(CMD_READ, '0, 1'b0);
      wait_results_drained();
   endtask

   // Wrap inside a block, block end past the size, start offsets past the size.
   task automatic test_block_wrap();
      write_reg(REG_BUFFER_SIZE, 11'd5);
      write_reg(REG_HOP_SIZE, 11'd3);
      write_reg(REG_READ_START, 11'd7);   // beyond size: restart loads 0
      write_reg(REG_WRITE_START, 11'd3);
      send_beat(CMD_RESTART, '0, 1'b1);
      send_beat(CMD_ACC, 24'sh010000, 1'b0);
      send_beat(CMD_ACC, 24'sh020000, 1'b0);
      send_beat(CMD_ACC, 24'sh030000, 1'b1);   // wraps, then 3+3 >= 5 gives 0
      send_beat(CMD_ACC, 24'sh040000, 1'b1);   // 0+3 lands on 3
      send_beat(CMD_ACC, -24'sh050000, 1'b0);
      send_beat(CMD_RESTART, '0, 1'b0);
      send_beat(CMD_ACC, 24'sh060000, 1'b1);
      send_beat(CMD_READ, '0, 1'b0);
      send_beat(CMD_READ, '0, 1'b0);
      wait_results_drained();
   endtask

   // Size above depth, size shrunk under live pointers, size zero.
   task automatic test_size_extremes();
      write_reg(REG_BUFFER_SIZE, 11'h7FF);  // clamps to full depth
      write_reg(REG_HOP_SIZE, 11'd1024);
      write_reg(REG_READ_START, 11'd1000);
      write_reg(REG_WRITE_START, 11'd1000);
      send_beat(CMD_RESTART, '0, 1'b0);
      send_beat(CMD_ACC, 24'sh400000, 1'b0);
      send_beat(CMD_ACC, 24'sh3FFFFF, 1'b0);
      send_beat(CMD_READ, '0, 1'b0);
      wait_results_drained();
      // both pointers now sit past the size: their entries are used once more
      write_reg(REG_BUFFER_SIZE, 11'd8);
      send_beat(CMD_ACC, 24'sh000777, 1'b1);
      send_beat(CMD_READ, '0, 1'b0);
      wait_results_drained();
      write_reg(REG_BUFFER_SIZE, 11'd0);    // behaves as a single entry
      send_beat(CMD_ACC, 24'sh111111, 1'b0);
      send_beat(CMD_ACC, 24'sh222222, 1'b1);
      send_beat(CMD_READ, '0, 1'b0);
      send_beat(CMD_READ, '0, 1'b0);
      wait_results_drained();
   endtask

   // Receiver holds off long enough for the result queue to fill and stall
   // the input; the sender keeps offering beats throughout.
   task automatic test_backpressure();
      tx_steady = 1'b1;
      rx_steady = 1'b1;
      write_reg(REG_BUFFER_SIZE, 11'd32);
      write_reg(REG_HOP_SIZE, 11'd8);
      write_reg(REG_READ_START, 11'd0);
      write_reg(REG_WRITE_START, 11'd0);
      send_beat(CMD_RESTART, '0, 1'b0);
      rsp_hold_left = 200;
      for (int k = 0; k < 40; k++)
         send_beat((k % 3 == 2) ? CMD_READ : CMD_ACC, draw_sample(), k % 8 == 7);
      // sender pauses until every result is back
      wait_results_drained();
      for (int k = 0; k < 12; k++)
         send_beat(CMD_READ, draw_sample(), 1'b0);
      wait_results_drained();
   endtask

   // Phases of random settings; mostly well-formed blocks with read-back,
   // plus cut-short blocks, noise beats and restarts.
   task automatic test_random_traffic(input int phases, input int beats_per_phase);
      int                  stop_at;
      int                  blk_len;
      int                  pick;
      logic [CFG_BITS-1:0] size_val;
      logic [CFG_BITS-1:0] ws_val;
      for (int ph = 0; ph < phases; ph++) begin
         wait_results_drained();
         tx_steady = ($urandom_range(0, 3) == 0);
         rx_steady = ($urandom_range(0, 3) == 0);
         if (ph % 4 == 3) begin
            // extreme sizes now and then, full 11-bit register values
            case ($urandom_range(0, 2))
               0:       size_val = '0;
               1:       size_val = 11'd1024;
               default: size_val = 11'h7FF;
            endcase
            write_reg(REG_HOP_SIZE, CFG_BITS'($urandom_range(0, 2047)));
            ws_val = CFG_BITS'($urandom_range(0, 2047));
         end else begin
            size_val = CFG_BITS'($urandom_range(1, 40));
            write_reg(REG_HOP_SIZE, CFG_BITS'($urandom_range(0, size_val + 3)));
            ws_val = CFG_BITS'($urandom_range(0, size_val + 2));
         end
         write_reg(REG_BUFFER_SIZE, size_val);
         write_reg(REG_WRITE_START, ws_val);
         // reading from where writing starts makes the reads meet real data
         if ($urandom_range(0, 1) == 1)
            write_reg(REG_READ_START, ws_val);
         else
            write_reg(REG_READ_START, CFG_BITS'($urandom_range(0, 2047)));
         if ($urandom_range(0, 3) != 0)
            send_beat(CMD_RESTART, draw_sample(), 1'($urandom_range(0, 1)));

         stop_at = beats_sent + beats_per_phase;
         while (beats_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
               blk_len = $urandom_range(1, 12);
               for (int k = 0; k < blk_len; k++)
                  send_beat(CMD_ACC, draw_sample(), k == blk_len - 1);
               repeat ($urandom_range(0, blk_len + 2))
                  send_beat(CMD_READ, draw_sample(), 1'($urandom_range(0, 1)));
            end else if (pick < 75) begin
               // block cut short by a restart
               repeat ($urandom_range(1, 6)) send_beat(CMD_ACC, draw_sample(), 1'b0);
               send_beat(CMD_RESTART, draw_sample(), 1'($urandom_range(0, 1)));
            end else if (pick < 95) begin
               send_beat(cmd_type'($urandom_range(0, 3)), draw_sample(),
                         1'($urandom_range(0, 1)));
            end else begin
               send_beat(CMD_RESTART, draw_sample(), 1'($urandom_range(0, 1)));
            end
         end
      end
      wait_results_drained();
   endtask

   initial begin
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.cmd       = CMD_NOP;
      req_ch.sample_in = '0;
      req_ch.last      = 1'b0;
      csr_ch.valid     = 1'b0;
      csr_ch.index     = REG_BUFFER_SIZE;
      csr_ch.wdata     = '0;
      for (int i = 0; i < DEPTH; i++) mirror_store[i] = '0;
      wr_ptr       = 0;
      rd_ptr       = 0;
      blk_start    = 0;
      blk_open     = 1'b0;
      cfg_size     = BUFFER_SIZE_RST;
      cfg_hop      = HOP_SIZE_RST;
      cfg_rd_start = READ_START_RST;
      cfg_wr_start = WRITE_START_RST;

      repeat (9) @(negedge clock);
      reset = 1'b0;

      // the clearing pass after reset holds req_ch.ready low; send_beat waits it out
      test_saturation_and_commands();
      test_block_wrap();
      test_size_extremes();
      test_backpressure();
      test_random_traffic(12, 105);

      wait_results_drained();
      repeat (10) @(negedge clock);  // catch any stray late beat
      if (err_count == 0 && pending_samples.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
